/* hdl/pressure_humidity_sensor_compensation_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sensor compensation block
// Shared wrappers that fix the clock of every concurrent check and, where wanted, its reset.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_HUMIDITY_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_HUMIDITY_SENSOR_COMPENSATION_DEFINES_SVH

// Check that is switched off while reset is applied.
`define PHSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that also holds while reset is applied.
`define PHSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/phsc_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor compensation package
// Types, register indexes and pipeline latencies shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phsc_pkg;

    localparam int LAT_FINE  = 5;
    localparam int LAT_PRESS = 78;
    localparam int LAT_HUM   = 10;
    localparam int LAT_TOTAL = LAT_FINE + LAT_PRESS;
    localparam int HUM_DLY   = LAT_PRESS - LAT_HUM;
    localparam int DIV_W     = 64;

    localparam logic signed [31:0] HUM_CLAMP     = 32'sd419430400;
    localparam logic [16:0]        HUM_CLAMP_OUT = 17'd102400;

    typedef enum logic [2:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_A    = 3'd1,
        CFG_PRESS_B    = 3'd2,
        CFG_PRESS_NINE = 3'd3,
        CFG_HUM_A      = 3'd4,
        CFG_HUM_B      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } coeff_t;

endpackage

/* hdl/phsc_ifs.sv */
// ----------------------------------------------------------------------------
// Sensor compensation channels
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface phsc_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;

    modport source (output valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                    temp_xlsb, hum_msb, hum_lsb, input ready);
    modport sink (input valid, press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb,
                  temp_xlsb, hum_msb, hum_lsb, output ready);
endinterface

interface phsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature;
    logic        [31:0] pressure;
    logic        [16:0] humidity;

    modport source (output valid, temperature, pressure, humidity, input ready);
    modport sink (input valid, temperature, pressure, humidity, output ready);
endinterface

interface phsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/phsc_temp.sv */
// ----------------------------------------------------------------------------
// Temperature compensation pipeline
// Five stages producing the fine temperature and the temperature result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phsc_temp (
    input  logic               clk,
    input  logic               en,
    input  logic [19:0]        adc_t,
    input  phsc_pkg::coeff_t   coeff,
    output logic signed [31:0] fine,
    output logic signed [31:0] temp
);
    import phsc_pkg::*;

    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] pa_reg;
    logic signed [31:0] pb_reg;
    logic signed [31:0] tv1_reg;
    logic signed [31:0] pc_reg;
    logic signed [31:0] fine_reg;
    logic signed [31:0] fine_d_reg;
    logic signed [31:0] temp_reg;

    assign t2 = coeff.t2;
    assign t3 = coeff.t3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= $signed({15'd0, adc_t[19:3]}) - $signed({15'd0, coeff.t1, 1'b0});
            b_reg      <= $signed({16'd0, adc_t[19:4]}) - $signed({16'd0, coeff.t1});
            pa_reg     <= a_reg * t2;
            pb_reg     <= b_reg * b_reg;
            tv1_reg    <= pa_reg >>> 11;
            pc_reg     <= (pb_reg >>> 12) * t3;
            fine_reg   <= tv1_reg + (pc_reg >>> 14);
            fine_d_reg <= fine_reg;
            temp_reg   <= (fine_reg + (fine_reg <<< 2) + 32'sd128) >>> 8;
        end
    end

    assign fine = fine_d_reg;
    assign temp = temp_reg;

endmodule

/* hdl/phsc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division of 64-bit magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phsc_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] quo,
    output logic               zero
);
    import phsc_pkg::*;

    logic [63:0] rem_reg [0:DIV_W];
    logic [63:0] quo_reg [0:DIV_W];
    logic [63:0] den_reg [0:DIV_W];
    logic        neg_reg [0:DIV_W];
    logic        zero_reg [0:DIV_W];
    logic signed [63:0] res_reg;
    logic        res_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= num[63] ? 64'd0 - num : num;
            den_reg[0]  <= den[63] ? 64'd0 - den : den;
            neg_reg[0]  <= num[63] ^ den[63];
            zero_reg[0] <= (den == 64'sd0);
        end
    end

    for (genvar k = 1; k <= DIV_W; k++)
    begin : g_stage
        logic [64:0] trial;
        logic [64:0] diff;

        assign trial = {rem_reg[k-1], quo_reg[k-1][63]};
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= diff[64] ? trial[63:0] : diff[63:0];
                quo_reg[k]  <= {quo_reg[k-1][62:0], ~diff[64]};
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg      <= neg_reg[DIV_W] ? $signed(64'd0 - quo_reg[DIV_W])
                                           : $signed(quo_reg[DIV_W]);
            res_zero_reg <= zero_reg[DIV_W];
        end
    end

    assign quo  = res_reg;
    assign zero = res_zero_reg;

endmodule

/* hdl/phsc_press.sv */
// ----------------------------------------------------------------------------
// Pressure compensation pipeline
// Numerator and divisor stages, the divider and the correction stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phsc_press (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] fine,
    input  logic [19:0]        adc_p,
    input  phsc_pkg::coeff_t   coeff,
    output logic [31:0]        pressure
);
    import phsc_pkg::*;

    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    logic signed [63:0] v1_reg;
    logic [19:0]        ap1_reg, ap2_reg, ap3_reg, ap4_reg, ap5_reg;
    logic [63:0]        ll_reg;
    logic [31:0]        hl_reg;
    logic signed [63:0] m5_reg, m5b_reg, m5c_reg;
    logic signed [63:0] m2_reg, m2b_reg, m2c_reg;
    logic signed [63:0] sq_reg;
    logic signed [63:0] m6_reg, m3_reg;
    logic signed [63:0] v2_reg, n1_reg;
    logic signed [63:0] m1_reg, pn_reg;
    logic signed [63:0] num_reg, den_reg;
    logic signed [63:0] pd;

    logic signed [63:0] q;
    logic               dz;
    logic signed [63:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [63:0] qs_reg;
    logic signed [63:0] m8_reg, m8b_reg, m8c_reg, m8d_reg;
    logic [63:0]        qll_reg;
    logic [31:0]        qhl_reg;
    logic signed [63:0] qq_reg;
    logic signed [63:0] m9_reg;
    logic               z1_reg, z2_reg, z3_reg, z4_reg;
    logic signed [63:0] sum;
    logic signed [63:0] res;
    logic [31:0]        press_reg;

    assign p2 = coeff.p2;
    assign p3 = coeff.p3;
    assign p4 = coeff.p4;
    assign p5 = coeff.p5;
    assign p6 = coeff.p6;
    assign p7 = coeff.p7;
    assign p8 = coeff.p8;
    assign p9 = coeff.p9;

    assign pd = 64'sd1048576 - $signed({44'd0, ap5_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg  <= 64'(fine) - 64'sd128000;
            ap1_reg <= adc_p;

            ll_reg  <= {32'd0, v1_reg[31:0]} * {32'd0, v1_reg[31:0]};
            hl_reg  <= v1_reg[63:32] * v1_reg[31:0];
            m5_reg  <= v1_reg * p5;
            m2_reg  <= v1_reg * p2;
            ap2_reg <= ap1_reg;

            sq_reg  <= $signed(ll_reg + {hl_reg[30:0], 1'b0, 32'd0});
            m5b_reg <= m5_reg;
            m2b_reg <= m2_reg;
            ap3_reg <= ap2_reg;

            m6_reg  <= sq_reg * p6;
            m3_reg  <= sq_reg * p3;
            m5c_reg <= m5b_reg;
            m2c_reg <= m2b_reg;
            ap4_reg <= ap3_reg;

            v2_reg  <= m6_reg + (m5c_reg <<< 17) + (64'(p4) <<< 35);
            n1_reg  <= (m3_reg >>> 8) + (m2c_reg <<< 12);
            ap5_reg <= ap4_reg;

            m1_reg  <= (64'sh0000_8000_0000_0000 + n1_reg) * $signed({1'b0, coeff.p1});
            pn_reg  <= (pd <<< 31) - v2_reg;

            den_reg <= m1_reg >>> 33;
            num_reg <= pn_reg * 64'sd3125;
        end
    end

    phsc_div u_div (
        .clk  (clk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (q),
        .zero (dz)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg  <= q;
            qs_reg  <= q >>> 13;
            m8_reg  <= q * p8;
            z1_reg  <= dz;

            qll_reg <= {32'd0, qs_reg[31:0]} * {32'd0, qs_reg[31:0]};
            qhl_reg <= qs_reg[63:32] * qs_reg[31:0];
            q2_reg  <= q1_reg;
            m8b_reg <= m8_reg;
            z2_reg  <= z1_reg;

            qq_reg  <= $signed(qll_reg + {qhl_reg[30:0], 1'b0, 32'd0});
            q3_reg  <= q2_reg;
            m8c_reg <= m8b_reg;
            z3_reg  <= z2_reg;

            m9_reg  <= qq_reg * p9;
            q4_reg  <= q3_reg;
            m8d_reg <= m8c_reg;
            z4_reg  <= z3_reg;

            press_reg <= z4_reg ? 32'd0 : res[31:0];
        end
    end

    assign sum = q4_reg + (m9_reg >>> 25) + (m8d_reg >>> 19);
    assign res = (sum >>> 8) + (64'(p7) <<< 4);

    assign pressure = press_reg;

endmodule

/* hdl/phsc_hum.sv */
// ----------------------------------------------------------------------------
// Humidity compensation pipeline
// Ten stages from the fine temperature and raw reading to clamped humidity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phsc_hum (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] fine,
    input  logic [15:0]        adc_h,
    input  phsc_pkg::coeff_t   coeff,
    output logic [16:0]        humidity
);
    import phsc_pkg::*;

    logic signed [15:0] h2, h4, h5;
    logic signed [7:0]  h6;

    logic signed [31:0] v_reg;
    logic [15:0]        ah1_reg, ah2_reg;
    logic signed [31:0] m5_reg, m6_reg, m3_reg;
    logic signed [31:0] x_reg, x4_reg, x5_reg, x6_reg;
    logic signed [31:0] a6_reg, a3_reg;
    logic signed [31:0] m63_reg;
    logic signed [31:0] mb2_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] w_reg, w8_reg, w9_reg;
    logic signed [31:0] ss_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] s;
    logic signed [31:0] w2;
    logic [16:0]        hum_reg;

    assign h2 = coeff.h2;
    assign h4 = coeff.h4;
    assign h5 = coeff.h5;
    assign h6 = coeff.h6;

    assign s  = w_reg >>> 15;
    assign w2 = w9_reg - (t_reg >>> 4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= fine - 32'sd76800;
            ah1_reg <= adc_h;

            m5_reg  <= h5 * v_reg;
            m6_reg  <= v_reg * h6;
            m3_reg  <= v_reg * $signed({1'b0, coeff.h3});
            ah2_reg <= ah1_reg;

            x_reg   <= ($signed({2'd0, ah2_reg, 14'd0}) - (32'(h4) <<< 20) - m5_reg
                        + 32'sd16384) >>> 15;
            a6_reg  <= m6_reg >>> 10;
            a3_reg  <= (m3_reg >>> 11) + 32'sd32768;

            m63_reg <= a6_reg * a3_reg;
            x4_reg  <= x_reg;

            mb2_reg <= ((m63_reg >>> 10) + 32'sd2097152) * h2;
            x5_reg  <= x4_reg;

            y_reg   <= (mb2_reg + 32'sd8192) >>> 14;
            x6_reg  <= x5_reg;

            w_reg   <= x6_reg * y_reg;

            ss_reg  <= s * s;
            w8_reg  <= w_reg;

            t_reg   <= (ss_reg >>> 7) * $signed({1'b0, coeff.h1});
            w9_reg  <= w8_reg;

            if (w2[31])
            begin
                hum_reg <= 17'd0;
            end
            else if (w2 > HUM_CLAMP)
            begin
                hum_reg <= HUM_CLAMP_OUT;
            end
            else
            begin
                hum_reg <= w2[28:12];
            end
        end
    end

    assign humidity = hum_reg;

endmodule

/* hdl/pressure_humidity_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// Pressure, temperature and humidity compensation
// Integer compensation of one raw sensor burst per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// The sample channel takes the eight raw readout bytes of one burst in a
// beat. The result channel gives temperature in hundredths of a degree,
// pressure in Q24.8 pascal and humidity in Q7.10 percent, one beat per
// sample and in the same order. The configuration channel writes the six
// calibration registers and is always ready; write it only while no samples
// are in flight.
// The pressure path is the longest one: seven stages form the numerator
// and divisor, a 64-bit divider of 66 stages forms one quotient bit per
// stage between its input and output registers, and five stages apply
// the corrections. Temperature and humidity are delayed to meet it.
// Throughput is one sample per cycle while the output is not stalled.
// The whole pipeline holds while a result waits and the receiver is not
// ready, so sample ready follows that state.
// Reset empties the pipeline and clears all calibration registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pressure_humidity_sensor_compensation (
    input  logic          clk,
    input  logic          rst_n,
    phsc_sample_if.sink   sample,
    phsc_result_if.source result,
    phsc_cfg_if.sink      cfg
);
    import phsc_pkg::*;

    logic                 adv;
    logic [LAT_TOTAL-1:0] vld_reg;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_coeffs_a_reg;
    logic [63:0] press_coeffs_b_reg;
    logic [15:0] press_coeff_nine_reg;
    logic [47:0] hum_coeffs_a_reg;
    logic [23:0] hum_coeffs_b_reg;
    coeff_t      coeff;

    logic [19:0]        adc_t;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
    logic [19:0]        adcp_dly_reg [0:LAT_FINE-1];
    logic [15:0]        adch_dly_reg [0:LAT_FINE-1];
    logic signed [31:0] fine;
    logic signed [31:0] temp;
    logic signed [31:0] temp_dly_reg [0:LAT_PRESS-1];
    logic [31:0]        press;
    logic [16:0]        hum;
    logic [16:0]        hum_dly_reg [0:HUM_DLY-1];

    assign adv          = !result.valid || result.ready;
    assign sample.ready = adv;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT_TOTAL-2:0], sample.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg      <= '0;
            press_coeffs_a_reg   <= '0;
            press_coeffs_b_reg   <= '0;
            press_coeff_nine_reg <= '0;
            hum_coeffs_a_reg     <= '0;
            hum_coeffs_b_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TEMP:       temp_coeffs_reg      <= cfg.data[47:0];
                CFG_PRESS_A:    press_coeffs_a_reg   <= cfg.data;
                CFG_PRESS_B:    press_coeffs_b_reg   <= cfg.data;
                CFG_PRESS_NINE: press_coeff_nine_reg <= cfg.data[15:0];
                CFG_HUM_A:      hum_coeffs_a_reg     <= cfg.data[47:0];
                CFG_HUM_B:      hum_coeffs_b_reg     <= cfg.data[23:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        coeff.t1 = temp_coeffs_reg[15:0];
        coeff.t2 = temp_coeffs_reg[31:16];
        coeff.t3 = temp_coeffs_reg[47:32];
        coeff.p1 = press_coeffs_a_reg[15:0];
        coeff.p2 = press_coeffs_a_reg[31:16];
        coeff.p3 = press_coeffs_a_reg[47:32];
        coeff.p4 = press_coeffs_a_reg[63:48];
        coeff.p5 = press_coeffs_b_reg[15:0];
        coeff.p6 = press_coeffs_b_reg[31:16];
        coeff.p7 = press_coeffs_b_reg[47:32];
        coeff.p8 = press_coeffs_b_reg[63:48];
        coeff.p9 = press_coeff_nine_reg;
        coeff.h1 = hum_coeffs_a_reg[7:0];
        coeff.h2 = hum_coeffs_a_reg[23:8];
        coeff.h3 = hum_coeffs_a_reg[31:24];
        coeff.h4 = hum_coeffs_a_reg[47:32];
        coeff.h5 = hum_coeffs_b_reg[15:0];
        coeff.h6 = hum_coeffs_b_reg[23:16];
    end

    assign adc_t = {sample.temp_msb, sample.temp_lsb, sample.temp_xlsb[7:4]};
    assign adc_p = {sample.press_msb, sample.press_lsb, sample.press_xlsb[7:4]};
    assign adc_h = {sample.hum_msb, sample.hum_lsb};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adcp_dly_reg[0] <= adc_p;
            adch_dly_reg[0] <= adc_h;
            for (int i = 1; i < LAT_FINE; i++)
            begin
                adcp_dly_reg[i] <= adcp_dly_reg[i-1];
                adch_dly_reg[i] <= adch_dly_reg[i-1];
            end
            temp_dly_reg[0] <= temp;
            for (int i = 1; i < LAT_PRESS; i++)
            begin
                temp_dly_reg[i] <= temp_dly_reg[i-1];
            end
            hum_dly_reg[0] <= hum;
            for (int i = 1; i < HUM_DLY; i++)
            begin
                hum_dly_reg[i] <= hum_dly_reg[i-1];
            end
        end
    end

    phsc_temp u_temp (
        .clk   (clk),
        .en    (adv),
        .adc_t (adc_t),
        .coeff (coeff),
        .fine  (fine),
        .temp  (temp)
    );

    phsc_press u_press (
        .clk      (clk),
        .en       (adv),
        .fine     (fine),
        .adc_p    (adcp_dly_reg[LAT_FINE-1]),
        .coeff    (coeff),
        .pressure (press)
    );

    phsc_hum u_hum (
        .clk      (clk),
        .en       (adv),
        .fine     (fine),
        .adc_h    (adch_dly_reg[LAT_FINE-1]),
        .coeff    (coeff),
        .humidity (hum)
    );

    assign result.valid       = vld_reg[LAT_TOTAL-1];
    assign result.temperature = temp_dly_reg[LAT_PRESS-1];
    assign result.pressure    = press;
    assign result.humidity    = hum_dly_reg[HUM_DLY-1];

endmodule

/* hdl/phsc_checker.sv */
// ----------------------------------------------------------------------------
// Sensor compensation port checker
// Concurrent checks on the handshakes and results seen at the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pressure_humidity_sensor_compensation_defines.svh"

module phsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] out_humidity
);

    `PHSC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_humidity), "stalled result beat changed")
    `PHSC_ASSERT(a_hum_range, out_valid |-> out_humidity <= 17'd102400, "humidity above clamp")
    `PHSC_ASSERT(a_ready_flow, in_ready == (!out_valid || out_ready), "sample ready does not follow output stall")
    `PHSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid && (in_valid || !in_valid), "result beat during reset")

endmodule

bind pressure_humidity_sensor_compensation phsc_checker u_phsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_humidity (result.humidity)
);

/* verif/pressure_humidity_sensor_compensation_tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the pressure, temperature and humidity compensation block
// Drives raw sensor bursts under several calibration settings, predicts each
// compensated reading in 32-bit and 64-bit arithmetic and compares every
// result beat field by field, with random idling on both channels but in the full-rate test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pressure_humidity_sensor_compensation_tb;
    import phsc_pkg::*;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int         CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [7:0] press_msb;
        logic [7:0] press_lsb;
        logic [7:0] press_xlsb;
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_xlsb;
        logic [7:0] hum_msb;
        logic [7:0] hum_lsb;
    } burst_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic        [31:0] pressure;
        logic        [16:0] humidity;
    } reading_t;

    logic clk;
    logic rst_n;

    phsc_sample_if sample ();
    phsc_result_if result ();
    phsc_cfg_if    cfg ();

    pressure_humidity_sensor_compensation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    logic [63:0] calib [0:5];
    reading_t    pending_readings [$];
    int          mismatches;
    int          cycles;
    bit          send_gaps;
    bit          recv_gaps;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic reading_t compensate(input burst_t b);
        reading_t           r;
        logic signed [31:0] adc_t, adc_h, t1, t2, t3, a, bb, fine, tv1, tv2;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, v, x, y, s;
        logic signed [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, pp, q;
        logic        [63:0] num, ma, mb, quo;
        adc_p = {b.press_msb, b.press_lsb, b.press_xlsb[7:4]};
        adc_t = {b.temp_msb, b.temp_lsb, b.temp_xlsb[7:4]};
        adc_h = {b.hum_msb, b.hum_lsb};

        t1 = calib[CFG_TEMP][15:0];
        t2 = $signed(calib[CFG_TEMP][31:16]);
        t3 = $signed(calib[CFG_TEMP][47:32]);
        a = (adc_t >>> 3) - (t1 <<< 1);
        tv1 = (a * t2) >>> 11;
        bb = (adc_t >>> 4) - t1;
        tv2 = (((bb * bb) >>> 12) * t3) >>> 14;
        fine = tv1 + tv2;
        r.temperature = (fine * 32'sd5 + 32'sd128) >>> 8;

        p1 = calib[CFG_PRESS_A][15:0];
        p2 = $signed(calib[CFG_PRESS_A][31:16]);
        p3 = $signed(calib[CFG_PRESS_A][47:32]);
        p4 = $signed(calib[CFG_PRESS_A][63:48]);
        p5 = $signed(calib[CFG_PRESS_B][15:0]);
        p6 = $signed(calib[CFG_PRESS_B][31:16]);
        p7 = $signed(calib[CFG_PRESS_B][47:32]);
        p8 = $signed(calib[CFG_PRESS_B][63:48]);
        p9 = $signed(calib[CFG_PRESS_NINE][15:0]);
        v1 = fine;
        v1 = v1 - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 64'sd0)
        begin
            r.pressure = '0;
        end
        else
        begin
            pp = 64'sd1048576 - adc_p;
            num = ((pp <<< 31) - v2) * 64'sd3125;
            ma = num[63] ? -num : num;
            mb = v1[63] ? -v1 : v1;
            quo = ma / mb;
            pp = (num[63] != v1[63]) ? -quo : quo;
            q = pp >>> 13;
            v1 = (p9 * q * q) >>> 25;
            v2 = (p8 * pp) >>> 19;
            pp = ((pp + v1 + v2) >>> 8) + (p7 <<< 4);
            r.pressure = pp[31:0];
        end

        h1 = calib[CFG_HUM_A][7:0];
        h2 = $signed(calib[CFG_HUM_A][23:8]);
        h3 = calib[CFG_HUM_A][31:24];
        h4 = $signed(calib[CFG_HUM_A][47:32]);
        h5 = $signed(calib[CFG_HUM_B][15:0]);
        h6 = $signed(calib[CFG_HUM_B][23:16]);
        v = fine - 32'sd76800;
        x = ((adc_h <<< 14) - (h4 <<< 20) - (h5 * v) + 32'sd16384) >>> 15;
        y = ((((((v * h6) >>> 10) * (((v * h3) >>> 11) + 32'sd32768)) >>> 10)
              + 32'sd2097152) * h2 + 32'sd8192) >>> 14;
        v = x * y;
        s = v >>> 15;
        v = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0)
        begin
            v = 0;
        end
        else if (v > HUM_CLAMP)
        begin
            v = HUM_CLAMP;
        end
        v = v >>> 12;
        r.humidity = v[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic send_burst(input burst_t b);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sample.valid      <= 1'b1;
        sample.press_msb  <= b.press_msb;
        sample.press_lsb  <= b.press_lsb;
        sample.press_xlsb <= b.press_xlsb;
        sample.temp_msb   <= b.temp_msb;
        sample.temp_lsb   <= b.temp_lsb;
        sample.temp_xlsb  <= b.temp_xlsb;
        sample.hum_msb    <= b.hum_msb;
        sample.hum_lsb    <= b.hum_lsb;
        do @(posedge clk); while (!sample.ready);
        pending_readings.push_back(compensate(b));
    endtask

    task automatic drain_pipeline();
        sample.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (LAT_TOTAL + 20) @(posedge clk);
    endtask

    task automatic write_calib(input logic [2:0] idx, input logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_TEMP:       calib[idx] = value & 64'h0000_FFFF_FFFF_FFFF;
            CFG_PRESS_A:    calib[idx] = value;
            CFG_PRESS_B:    calib[idx] = value;
            CFG_PRESS_NINE: calib[idx] = value & 64'hFFFF;
            CFG_HUM_A:      calib[idx] = value & 64'h0000_FFFF_FFFF_FFFF;
            CFG_HUM_B:      calib[idx] = value & 64'hFF_FFFF;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_calib(input logic [63:0] tc, pa, pb, p9, ha, hb);
        drain_pipeline();
        write_calib(CFG_TEMP, tc);
        write_calib(CFG_PRESS_A, pa);
        write_calib(CFG_PRESS_B, pb);
        write_calib(CFG_PRESS_NINE, p9);
        write_calib(CFG_HUM_A, ha);
        write_calib(CFG_HUM_B, hb);
    endtask

    task automatic load_typical_calib();
        load_calib({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                   64'd6000,
                   {16'd325, 8'd0, 16'd362, 8'd75},
                   {8'd30, 16'd50});
    endtask

    function automatic burst_t random_burst();
        return {$urandom, $urandom};
    endfunction

    function automatic burst_t plausible_burst();
        burst_t b;
        b = random_burst();
        b.press_msb = $urandom_range(8'h30, 8'h70);
        b.temp_msb  = $urandom_range(8'h70, 8'h90);
        b.hum_msb   = $urandom_range(8'h40, 8'h90);
        return b;
    endfunction

    task automatic test_zero_divisor_at_reset();
        send_burst('0);
        send_burst('1);
        repeat (6) send_burst(random_burst());
    endtask

    task automatic test_field_extremes();
        load_typical_calib();
        send_burst('0);
        send_burst('1);
        send_burst({8{8'h80}});
        send_burst({8{8'h7F}});
        send_burst({8{8'h0F}});
        send_burst({8{8'hF0}});
        send_burst({8{8'h55}});
        send_burst({8{8'hAA}});
        send_burst({8'h52, 8'h4A, 8'hC0, 8'h80, 8'h00, 8'h00, 8'h6B, 8'h10});
        send_burst({8'h52, 8'h4A, 8'hCF, 8'h80, 8'h00, 8'h0F, 8'hFF, 8'hFF});
    endtask

    task automatic test_calib_extremes();
        load_calib('1, '1, '1, 64'hFFFF, '1, '1);
        repeat (10) send_burst(random_burst());
        load_calib({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 64'h8000,
                   {16'h8000, 8'hFF, 16'h8000, 8'hFF}, {8'h80, 16'h8000});
        repeat (10) send_burst(random_burst());
        load_calib({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h7FFF,
                   {16'h7FFF, 8'h00, 16'h7FFF, 8'h00}, {8'h7F, 16'h7FFF});
        repeat (10) send_burst(random_burst());
        drain_pipeline();
        write_calib(CFG_SPARE_LO, '1);
        write_calib(CFG_SPARE_HI, '1);
        repeat (10) send_burst(random_burst());
    endtask

    task automatic test_typical_readings();
        load_typical_calib();
        repeat (200) send_burst(plausible_burst());
        repeat (50) send_burst(random_burst());
    endtask

    task automatic test_random_calib();
        repeat (6)
        begin
            load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            repeat (40) send_burst($urandom_range(0, 1) ? plausible_burst() : random_burst());
        end
    endtask

    task automatic test_output_backpressure();
        load_typical_calib();
        hold_left = 400;
        repeat (120) send_burst(plausible_burst());
    endtask

    task automatic test_full_rate();
        drain_pipeline();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (100) send_burst(plausible_burst());
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else if (recv_gaps && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                report_mismatch("unexpected beat, temperature", result.temperature, 0);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (result.temperature !== want.temperature)
                    report_mismatch("temperature", result.temperature, want.temperature);
                if (result.pressure !== want.pressure)
                    report_mismatch("pressure", result.pressure, want.pressure);
                if (result.humidity !== want.humidity)
                    report_mismatch("humidity", result.humidity, want.humidity);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pressure_humidity_sensor_compensation_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        cycles            = 0;
        mismatches        = 0;
        hold_left         = 0;
        send_gaps         = 1'b1;
        recv_gaps         = 1'b1;
        for (int i = 0; i < 6; i++) calib[i] = '0;
        rst_n             <= 1'b0;
        sample.valid      <= 1'b0;
        sample.press_msb  <= '0;
        sample.press_lsb  <= '0;
        sample.press_xlsb <= '0;
        sample.temp_msb   <= '0;
        sample.temp_lsb   <= '0;
        sample.temp_xlsb  <= '0;
        sample.hum_msb    <= '0;
        sample.hum_lsb    <= '0;
        result.ready      <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_TEMP;
        cfg.data          <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_divisor_at_reset();
        test_field_extremes();
        test_calib_extremes();
        test_typical_readings();
        test_random_calib();
        test_output_backpressure();
        test_full_rate();

        sample.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (LAT_TOTAL + 20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("pressure_humidity_sensor_compensation_tb: PASS");
        end
        else
        begin
            $display("pressure_humidity_sensor_compensation_tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/phsc_pkg.sv
hdl/phsc_ifs.sv
hdl/phsc_temp.sv
hdl/phsc_div.sv
hdl/phsc_press.sv
hdl/phsc_hum.sv
hdl/pressure_humidity_sensor_compensation.sv
hdl/phsc_checker.sv
verif/pressure_humidity_sensor_compensation_tb.sv
